FILE: rtl/hsh_pkg.sv
// shared types, constants and defaults for the hyperplane sign hash
package hsh_pkg;

    localparam int MAX_PLANES_DEF    = 16;
    localparam int VECTOR_LENGTH_DEF = 128;

    localparam int PLANE_W  = 4;
    localparam int ELEM_W   = 7;
    localparam int VAL_W    = 16;
    localparam int PROD_W   = 2 * VAL_W;
    localparam int ACC_W    = 40;
    localparam int OUT_BITS = 16;
    localparam int PIU_W    = 5;
    localparam int LIMIT_W  = 38;
    localparam int TDATA_W  = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [PIU_W-1:0]   PIU_RESET   = 5'd13;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 38'd107374182;

    localparam logic [CFG_IDX_W-1:0] REG_PLANES_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_LIMIT   = 1'd1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 8;

    typedef enum logic {
        OP_LOAD,
        OP_POINT
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [PLANE_W-1:0]  plane;
        logic [ELEM_W-1:0]   element;
        logic [VAL_W-1:0]    value;
        logic                mac_en;
        logic                last;
    } op_t;

    typedef struct packed {
        logic [PIU_W-1:0]   planes_in_use;
        logic [LIMIT_W-1:0] close_limit;
    } cfg_t;

endpackage

FILE: rtl/hsh_ram.sv
// generic single-write, single-read ram with registered read data
module hsh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/hsh_fifo.sv
// small register-based fifo used between the pipeline parts
module hsh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg < CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/hsh_front.sv
// input stage: accepts requests, drops the ones with no effect, decodes the rest
module hsh_front #(
    parameter int MAX_PLANES    = hsh_pkg::MAX_PLANES_DEF,
    parameter int VECTOR_LENGTH = hsh_pkg::VECTOR_LENGTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // plane [3:0], element [10:4], value [26:11], zero [31:27]
    input  logic [hsh_pkg::TDATA_W-1:0] s_axis_tdata,
    // req_type [0]
    input  logic                        s_axis_tuser,
    input  logic                        s_axis_tlast,
    output logic                        op_valid,
    input  logic                        op_ready,
    output hsh_pkg::op_t                op_data
);

    logic         valid_reg, valid_next;
    hsh_pkg::op_t op_reg, op_next;
    logic         accept;
    logic         plane_ok, elem_ok, keep;
    logic [hsh_pkg::PLANE_W-1:0] in_plane;
    logic [hsh_pkg::ELEM_W-1:0]  in_element;

    assign in_plane   = s_axis_tdata[3:0];
    assign in_element = s_axis_tdata[10:4];

    assign s_axis_tready = !valid_reg || op_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        plane_ok = 32'(in_plane) < MAX_PLANES;
        elem_ok  = 32'(in_element) < VECTOR_LENGTH;
        op_next.kind    = (s_axis_tuser == hsh_pkg::REQ_LOAD) ? hsh_pkg::OP_LOAD
                                                               : hsh_pkg::OP_POINT;
        op_next.plane   = in_plane;
        op_next.element = in_element;
        op_next.value   = s_axis_tdata[26:11];
        op_next.mac_en  = elem_ok;
        op_next.last    = s_axis_tlast;
        // loads out of range and point elements that add nothing and do not close
        if (s_axis_tuser == hsh_pkg::REQ_LOAD) begin
            keep = plane_ok && elem_ok;
        end else begin
            keep = elem_ok || s_axis_tlast;
        end
        valid_next = valid_reg;
        if (accept) begin
            valid_next = keep;
        end else if (op_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg <= op_next;
        end
    end

    assign op_valid = valid_reg;
    assign op_data  = op_reg;

endmodule

FILE: rtl/hsh_back.sv
// execution pipeline: plane store, per-plane multiply-accumulate, hash result queue
module hsh_back #(
    parameter int MAX_PLANES    = hsh_pkg::MAX_PLANES_DEF,
    parameter int VECTOR_LENGTH = hsh_pkg::VECTOR_LENGTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  hsh_pkg::cfg_t               cfg,
    input  logic                        op_valid,
    output logic                        op_ready,
    input  hsh_pkg::op_t                op_data,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // hash [15:0], near_mask [31:16]
    output logic [hsh_pkg::TDATA_W-1:0] m_axis_tdata
);

    localparam int AW     = VECTOR_LENGTH > 1 ? $clog2(VECTOR_LENGTH) : 1;
    localparam int NOUT   = MAX_PLANES < hsh_pkg::OUT_BITS ? MAX_PLANES : hsh_pkg::OUT_BITS;
    localparam int RES_W  = $clog2(hsh_pkg::OUT_DEPTH + 1);
    localparam int VAL_W  = hsh_pkg::VAL_W;
    localparam int PROD_W = hsh_pkg::PROD_W;
    localparam int ACC_W  = hsh_pkg::ACC_W;

    // issue
    logic            issue, is_result;
    logic [31:0]     el_wide;
    logic [AW-1:0]   addr;
    logic [RES_W-1:0] reserved_reg, reserved_next;
    logic            out_push_ready, out_pop;

    // stage 1: ram read in flight
    logic             s1_valid_reg, s1_mac_reg, s1_last_reg;
    logic [VAL_W-1:0] s1_value_reg;
    logic [VAL_W-1:0] coef [MAX_PLANES];

    // stage 2: products
    logic                     s2_valid_reg, s2_mac_reg, s2_last_reg;
    logic signed [PROD_W-1:0] prod_reg [MAX_PLANES];

    // stage 3: accumulators and closed dot products
    logic signed [ACC_W-1:0] acc_reg [MAX_PLANES];
    logic signed [ACC_W-1:0] acc_next [MAX_PLANES];
    logic signed [ACC_W-1:0] fin_reg [NOUT];
    logic                    s3_valid_reg;

    // stage 4: result bits
    logic [hsh_pkg::PIU_W-1:0]    used;
    logic [hsh_pkg::OUT_BITS-1:0] hash_bits, near_bits;

    assign is_result = (op_data.kind == hsh_pkg::OP_POINT) && op_data.last;
    // a closing request goes ahead only when the result queue has room reserved
    assign op_ready  = !is_result || (reserved_reg < RES_W'(hsh_pkg::OUT_DEPTH));
    assign issue     = op_valid && op_ready;
    assign el_wide   = 32'(op_data.element);
    assign addr      = el_wide[AW-1:0];

    for (genvar j = 0; j < MAX_PLANES; j++) begin : g_lane
        logic we;
        logic signed [ACC_W:0] sum;

        assign we = issue && (op_data.kind == hsh_pkg::OP_LOAD) && (32'(op_data.plane) == j);

        hsh_ram #(
            .WIDTH (VAL_W),
            .DEPTH (VECTOR_LENGTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (we),
            .waddr (addr),
            .wdata (op_data.value),
            .raddr (addr),
            .rdata (coef[j])
        );

        always_ff @(posedge aclk) begin
            prod_reg[j] <= signed'(s1_value_reg) * signed'(coef[j]);
        end

        always_comb begin
            sum = (ACC_W + 1)'(acc_reg[j]) + (ACC_W + 1)'(prod_reg[j]);
            acc_next[j] = acc_reg[j];
            if (s2_valid_reg && s2_mac_reg) begin
                if (sum[ACC_W] != sum[ACC_W-1]) begin
                    acc_next[j] = sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                             : {1'b0, {(ACC_W - 1){1'b1}}};
                end else begin
                    acc_next[j] = sum[ACC_W-1:0];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                acc_reg[j] <= '0;
            end else if (s2_valid_reg && s2_last_reg) begin
                acc_reg[j] <= '0;
            end else begin
                acc_reg[j] <= acc_next[j];
            end
        end

        if (j < NOUT) begin : g_fin
            always_ff @(posedge aclk) begin
                if (s2_valid_reg && s2_last_reg) begin
                    fin_reg[j] <= acc_next[j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            reserved_reg <= '0;
        end else begin
            s1_valid_reg <= issue && (op_data.kind == hsh_pkg::OP_POINT);
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg && s2_last_reg;
            reserved_reg <= reserved_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_mac_reg   <= op_data.mac_en;
        s1_last_reg  <= op_data.last;
        s1_value_reg <= op_data.value;
        s2_mac_reg   <= s1_mac_reg;
        s2_last_reg  <= s1_last_reg;
    end

    always_comb begin
        reserved_next = reserved_reg;
        if (issue && is_result && !out_pop) begin
            reserved_next = reserved_reg + 1'b1;
        end else if (out_pop && !(issue && is_result)) begin
            reserved_next = reserved_reg - 1'b1;
        end
    end

    always_comb begin
        logic [ACC_W-1:0] mag;
        used = (cfg.planes_in_use > hsh_pkg::PIU_W'(NOUT)) ? hsh_pkg::PIU_W'(NOUT)
                                                           : cfg.planes_in_use;
        hash_bits = '0;
        near_bits = '0;
        mag = '0;
        for (int j = 0; j < NOUT; j++) begin
            mag = fin_reg[j][ACC_W-1] ? ACC_W'(-fin_reg[j]) : ACC_W'(fin_reg[j]);
            if (hsh_pkg::PIU_W'(j) < used) begin
                hash_bits[j] = !fin_reg[j][ACC_W-1] && (fin_reg[j] != '0);
                near_bits[j] = mag < ACC_W'(cfg.close_limit);
            end
        end
    end

    assign out_pop = m_axis_tvalid && m_axis_tready;

    hsh_fifo #(
        .WIDTH (hsh_pkg::TDATA_W),
        .DEPTH (hsh_pkg::OUT_DEPTH)
    ) u_out_q (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s3_valid_reg),
        .push_ready (out_push_ready),
        .push_data  ({near_bits, hash_bits}),
        .pop_valid  (m_axis_tvalid),
        .pop_ready  (m_axis_tready),
        .pop_data   (m_axis_tdata)
    );

    a_reserved_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        reserved_reg <= RES_W'(hsh_pkg::OUT_DEPTH))
        else $error("result reservations exceed queue depth");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> out_push_ready)
        else $error("result pushed into a full queue");

    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && s2_last_reg) |=> (acc_reg[0] == '0))
        else $error("accumulator not cleared after closing element");

    a_reserve_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && is_result && !out_pop) |=> (reserved_reg == $past(reserved_reg) + 1'b1))
        else $error("closing request issued without a reservation");

endmodule

FILE: rtl/hyperplane_sign_hash.sv
// Random-hyperplane sign hash. Coefficient loads (tuser 0) and point elements
// (tuser 1) are both taken at one request per clock cycle while the result
// queue has room. A point element is multiplied against every plane at once,
// one multiplier and one 40-bit saturating accumulator per plane, each plane
// holding its coefficients in a ram of its own with one read port. The
// element with tlast closes the point: its hash and near mask pass through
// the pipeline into a queue of eight results on the result channel, and the
// accumulators start again from zero. A coefficient must be loaded before
// any point reads it; the store has no reset and needs no clearing pass. The
// user must write configuration only while the block is idle (not enforced).
module hyperplane_sign_hash #(
    parameter int MAX_PLANES    = hsh_pkg::MAX_PLANES_DEF,
    parameter int VECTOR_LENGTH = hsh_pkg::VECTOR_LENGTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [hsh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hsh_pkg::LIMIT_W-1:0]   cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // plane [3:0], element [10:4], value [26:11], zero [31:27]
    input  logic [hsh_pkg::TDATA_W-1:0]   s_axis_tdata,
    // req_type [0]
    input  logic                          s_axis_tuser,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // hash [15:0], near_mask [31:16]
    output logic [hsh_pkg::TDATA_W-1:0]   m_axis_tdata
);

    localparam int OP_W = $bits(hsh_pkg::op_t);

    hsh_pkg::cfg_t cfg_reg, cfg_next;
    hsh_pkg::op_t  front_op, back_op;
    logic          front_valid, front_ready;
    logic          back_valid, back_ready;
    logic [OP_W-1:0] back_op_bits;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                hsh_pkg::REG_PLANES_IN_USE:
                    cfg_next.planes_in_use = cfg_wdata[hsh_pkg::PIU_W-1:0];
                hsh_pkg::REG_CLOSE_LIMIT:
                    cfg_next.close_limit = cfg_wdata;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.planes_in_use <= hsh_pkg::PIU_RESET;
            cfg_reg.close_limit   <= hsh_pkg::LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    hsh_front #(
        .MAX_PLANES    (MAX_PLANES),
        .VECTOR_LENGTH (VECTOR_LENGTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .op_valid      (front_valid),
        .op_ready      (front_ready),
        .op_data       (front_op)
    );

    hsh_fifo #(
        .WIDTH (OP_W),
        .DEPTH (hsh_pkg::QUEUE_DEPTH)
    ) u_op_q (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_op),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_op_bits)
    );

    assign back_op = hsh_pkg::op_t'(back_op_bits);

    hsh_back #(
        .MAX_PLANES    (MAX_PLANES),
        .VECTOR_LENGTH (VECTOR_LENGTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .op_valid      (back_valid),
        .op_ready      (back_ready),
        .op_data       (back_op),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
